// ===== rtl/srrc_pkg.sv =====
// Shared types and constants for the symbol rate register calculator.
`default_nettype none
package srrc_pkg;

  localparam int unsigned RateW    = 24;
  localparam int unsigned ClkW     = 27;
  localparam int unsigned WordW    = 21;
  localparam int unsigned InvW     = 8;
  localparam int unsigned NumWW    = RateW + ClkW;
  localparam int unsigned NumIW    = 32;
  localparam int unsigned NumThr   = 7;
  localparam int unsigned WordSteps = NumWW;
  localparam int unsigned InvSteps  = NumIW;

  localparam logic [ClkW-1:0] SysclkReset = 27'd57840000;

  // Register index of the system clock register.
  localparam logic RegSysclk = 1'b0;

  // Threshold divisors, tightest first.
  function automatic logic [9:0] thr_div(input logic [2:0] idx);
    logic [9:0] d;
    case (idx)
      3'd0:    d = 10'd984;
      3'd1:    d = 10'd640;
      3'd2:    d = 10'd492;
      3'd3:    d = 10'd320;
      3'd4:    d = 10'd246;
      3'd5:    d = 10'd160;
      3'd6:    d = 10'd123;
      default: d = 10'd123;
    endcase
    return d;
  endfunction

  // Data carried through each division step.
  typedef struct packed {
    logic [1:0]       dec;
    logic             fil;
    logic [ClkW-1:0]  clk;
    logic [RateW-1:0] rate;
    logic [NumWW-1:0] num_w;
    logic [ClkW-1:0]  rem_w;
    logic [WordW-1:0] q_w;
    logic [NumIW-1:0] num_i;
    logic [RateW-1:0] rem_i;
    logic [InvW-1:0]  q_i;
    logic             sat;
  } div_t;

endpackage
`default_nettype wire

// ===== rtl/srrc_front.sv =====
// Front stages: threshold compares, then decimation choice and dividends.
`default_nettype none
module srrc_front import srrc_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             en_i,
  input  wire logic             valid_i,
  input  wire logic [RateW-1:0] rate_i,
  input  wire logic [ClkW-1:0]  sysclk_i,
  output logic                  valid_o,
  output div_t                  data_o
);

  logic                  v1_q;
  logic [RateW-1:0]      rate1_q;
  logic [ClkW-1:0]       clk1_q;
  logic [NumThr-1:0]     lt1_q, lt1_d;
  logic                  v2_q;
  div_t                  data2_q, data2_d;

  // A rate lies below floor(clk*10/D) exactly when (rate+1)*D <= clk*10.
  always_comb begin
    logic [34:0] clk10;
    logic [34:0] rp1;
    clk10 = 35'(sysclk_i) * 35'd10;
    rp1   = 35'(rate_i) + 35'd1;
    for (int i = 0; i < NumThr; i++) begin
      lt1_d[i] = (rp1 * 35'(thr_div(3'(i)))) <= clk10;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rate1_q <= rate_i;
      clk1_q  <= sysclk_i;
      lt1_q   <= lt1_d;
    end
  end

  // The first threshold met sets decimation and filter, then the dividends are formed.
  always_comb begin
    logic [1:0] dec;
    logic       fil;
    logic       hit;
    dec = 2'd0;
    fil = 1'b0;
    hit = 1'b0;
    for (int i = 0; i < NumThr; i++) begin
      if (!hit && lt1_q[i]) begin
        hit = 1'b1;
        dec = 2'(3 - (i / 2));
        fil = ((i % 2) == 0);
      end
    end
    data2_d       = '0;
    data2_d.dec   = dec;
    data2_d.fil   = fil;
    data2_d.clk   = clk1_q;
    data2_d.rate  = rate1_q;
    data2_d.num_w = NumWW'(rate1_q) << (5'd24 + 5'(dec));
    data2_d.num_i = (NumIW'({clk1_q, 4'b0000}) >> dec) + NumIW'(rate1_q >> 1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en_i) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data2_q <= data2_d;
    end
  end

  assign valid_o = v2_q;
  assign data_o  = data2_q;

endmodule
`default_nettype wire

// ===== rtl/srrc_div_stage.sv =====
// One registered restoring-division step for the baud word and the inverse.
`default_nettype none
module srrc_div_stage import srrc_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic en_i,
  input  wire logic step_inv_i,
  input  wire logic valid_i,
  input  wire div_t data_i,
  output logic      valid_o,
  output div_t      data_o
);

  logic valid_q;
  div_t data_q, data_d;

  // Shift one dividend bit into each partial remainder and subtract when it fits.
  always_comb begin
    logic [ClkW:0]  rw;
    logic [RateW:0] ri;
    logic           bw;
    logic           bi;
    rw = {data_i.rem_w, data_i.num_w[NumWW-1]};
    ri = {data_i.rem_i, data_i.num_i[NumIW-1]};
    bw = rw >= {1'b0, data_i.clk};
    bi = ri >= {1'b0, data_i.rate};
    data_d       = data_i;
    data_d.num_w = data_i.num_w << 1;
    data_d.rem_w = bw ? ClkW'(rw - {1'b0, data_i.clk}) : ClkW'(rw);
    data_d.q_w   = {data_i.q_w[WordW-2:0], bw};
    if (step_inv_i) begin
      data_d.num_i = data_i.num_i << 1;
      data_d.rem_i = bi ? RateW'(ri - {1'b0, data_i.rate}) : RateW'(ri);
      data_d.q_i   = {data_i.q_i[InvW-2:0], bi};
      data_d.sat   = data_i.sat | data_i.q_i[InvW-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule
`default_nettype wire

// ===== rtl/symbol_rate_register_calc.sv =====
// Top level of the symbol rate register calculator.
// The block takes one symbol rate per cycle and returns decimation, filter
// select, baud word and rounded inverse baud value for the configured system
// clock. A rate passes through the threshold compare register, the decimation
// choice register and one division step for each of the 51 quotient bits of
// the baud word division, with the 32-bit inverse division running alongside
// in the first 32 of those steps. A new rate may enter in every cycle; the
// whole pipeline holds while a finished result waits on the output. The
// system clock register sits at address 0.
`default_nettype none
module symbol_rate_register_calc import srrc_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // APB configuration port.
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  // Input stream.
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,  // [23:0] requested rate
  // Output stream.
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata   // [1:0] decimation, [2] filter_select,
                                          // [23:3] baud_word, [31:24] baud_inverse,
                                          // [32] inverse_saturated, [39:33] zero
);

  logic [ClkW-1:0] sysclk_q;
  logic            en;
  logic            v [WordSteps+1];
  div_t            d [WordSteps+1];

  // Configuration register write and read-back.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegSysclk) ? 32'(sysclk_q) : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sysclk_q <= SysclkReset;
    end else if (psel && penable && pwrite && paddr[2] == RegSysclk) begin
      sysclk_q <= pwdata[ClkW-1:0];
    end
  end

  // The pipeline advances unless a result is held on the output.
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  srrc_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (s_axis_tvalid),
    .rate_i   (s_axis_tdata),
    .sysclk_i (sysclk_q),
    .valid_o  (v[0]),
    .data_o   (d[0])
  );

  // Division steps, one quotient bit per stage.
  for (genvar g = 0; g < WordSteps; g++) begin : g_div
    srrc_div_stage u_stage (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .en_i       (en),
      .step_inv_i ((g < InvSteps) ? 1'b1 : 1'b0),
      .valid_i    (v[g]),
      .data_i     (d[g]),
      .valid_o    (v[g+1]),
      .data_o     (d[g+1])
    );
  end

  // Result formatting from the last stage.
  assign m_axis_tvalid = v[WordSteps];
  assign m_axis_tdata  = {7'd0,
                          d[WordSteps].sat,
                          d[WordSteps].sat ? 8'hFF : d[WordSteps].q_i,
                          d[WordSteps].q_w,
                          d[WordSteps].fil,
                          d[WordSteps].dec};

endmodule
`default_nettype wire
